// ===== src/hwm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hwm_pkg
// Shared widths, register indexes and item types for the heartbeat watchdog.
// ----------------------------------------------------------------------------
package hwm_pkg;

  localparam int TIME_W    = 48;
  localparam int VALUE_W   = 64;
  localparam int TIMEOUT_W = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 64;
  localparam int IN_DATA_W  = 160;
  localparam int OUT_DATA_W = 72;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WRAP_LIMIT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SEND_ENABLE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_READ_PRESENT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WRITE_PRESENT = 3'd4;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 32'd1000;

  typedef struct packed {
    logic [TIMEOUT_W-1:0] timeout_ms;
    logic [VALUE_W-1:0]   wrap_limit;
    logic                 send_enable;
    logic                 read_present;
    logic                 write_present;
  } cfg_t;

  typedef struct packed {
    logic [TIME_W-1:0]  partner_update_ms;
    logic [VALUE_W-1:0] partner_value;
    logic [TIME_W-1:0]  now_ms;
  } in_item_t;

  typedef struct packed {
    logic               entered_normal;
    logic               entered_timeout;
    logic               entered_frozen;
    logic               is_normal;
    logic               is_timed_out;
    logic               is_frozen;
    logic               write_request;
    logic [VALUE_W-1:0] heartbeat_out;
  } out_item_t;

endpackage
`default_nettype wire

// ===== src/heartbeat_watchdog_monitor.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// heartbeat_watchdog_monitor
// Watches a partner heartbeat for frozen values and stale updates, and
// produces the outgoing heartbeat value, one result item per tick item.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Width  Carries
//  in_      slave      160    one tick: now, partner value, partner update time
//  out_     master     72     outgoing heartbeat, write request, status, strobes
//  cfg_     write      64     timeout, wrap limit, send/read/write enables
//
//  One item per cycle sustained while out_ is not stalled; an accepted item
//  passes the input register, then evaluation into the result register,
//  and out_tvalid for it rises once it is held in the result register.
//  The evaluation path is a 64-bit increment and wrap compare beside the
//  48-bit age subtract and timeout compares.
//  Reset is synchronous, active low; it restores the register defaults and
//  the start-up grace state. A stall on out_ holds the result register and
//  the input register, so in_tready drops only when both are full.
//
module heartbeat_watchdog_monitor
  import hwm_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // in_tdata, lowest bit up: now_ms[47:0], partner_value[63:0],
  //   partner_update_ms[47:0]
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // out_tdata, lowest bit up: heartbeat_out[63:0], write_request, is_frozen,
  //   is_timed_out, is_normal, entered_frozen, entered_timeout,
  //   entered_normal, one zero pad bit
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t      cfg;
  in_item_t  item;
  out_item_t result;
  logic      item_valid;
  logic      advance;

  // register bank
  hwm_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // tick item capture
  hwm_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  // watchdog state and result register
  hwm_eval u_eval (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item       (item),
    .advance    (advance),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .result     (result)
  );

  // top bit is the byte pad
  assign out_tdata = {1'b0, result};

endmodule
`default_nettype wire

// ===== src/hwm_cfg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hwm_cfg
// Configuration register bank, written through a plain write port.
// ----------------------------------------------------------------------------
module hwm_cfg
  import hwm_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                       cfg
);

  cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_TIMEOUT:       cfg_nxt.timeout_ms    = cfg_wdata[TIMEOUT_W-1:0];
        CFG_WRAP_LIMIT:    cfg_nxt.wrap_limit    = cfg_wdata[VALUE_W-1:0];
        CFG_SEND_ENABLE:   cfg_nxt.send_enable   = cfg_wdata[0];
        CFG_READ_PRESENT:  cfg_nxt.read_present  = cfg_wdata[0];
        CFG_WRITE_PRESENT: cfg_nxt.write_present = cfg_wdata[0];
        default:           cfg_nxt = cfg_r;  // unknown index: ignored
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.timeout_ms    <= TIMEOUT_RESET;
      cfg_r.wrap_limit    <= '0;
      cfg_r.send_enable   <= 1'b0;
      cfg_r.read_present  <= 1'b0;
      cfg_r.write_present <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

// ===== src/hwm_in_stage.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hwm_in_stage
// Input register: captures one tick item, releases it when evaluation advances.
// ----------------------------------------------------------------------------
module hwm_in_stage
  import hwm_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [IN_DATA_W-1:0] in_tdata,
  input  wire logic                 advance,
  output logic                      item_valid,
  output in_item_t                  item
);

  logic     valid_r, valid_nxt;
  in_item_t item_r;

  assign in_tready = !valid_r || advance;

  always_comb begin
    valid_nxt = valid_r;
    if (in_tready) valid_nxt = in_tvalid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r <= in_item_t'(in_tdata);
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule
`default_nettype wire

// ===== src/hwm_eval.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hwm_eval
// Watchdog state update, result register: one tick item per cycle unless stalled.
// ----------------------------------------------------------------------------
module hwm_eval
  import hwm_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  cfg_t       cfg,
  input  wire logic  item_valid,
  input  in_item_t   item,
  output logic       advance,
  output logic       out_valid,
  input  wire logic  out_ready,
  output out_item_t  result
);

  logic               grace_r, grace_nxt;
  logic               monitoring_r, monitoring_nxt;
  logic [VALUE_W-1:0] last_seen_r, last_seen_nxt;
  logic [TIME_W-1:0]  last_change_r, last_change_nxt;
  logic               frozen_r, frozen_nxt;
  logic               fault_r, fault_nxt;
  logic               normal_r, normal_nxt;
  logic [VALUE_W-1:0] own_count_r, own_count_nxt;
  logic               out_valid_r;
  out_item_t          result_r, result_nxt;

  logic [TIME_W-1:0]  timeout_ext;
  logic [TIME_W-1:0]  change_age, update_age;
  logic               stale_change, stale_update;
  logic               grace_end, changed;
  logic [VALUE_W-1:0] seen_ref, sum;
  logic               frz0, flt0, nrm0;
  logic               ent_frz, ent_to, ent_nrm;

  assign advance     = !out_valid_r || out_ready;
  assign timeout_ext = {{(TIME_W-TIMEOUT_W){1'b0}}, cfg.timeout_ms};
  assign grace_end   = item.now_ms > timeout_ext;

  always_comb begin
    grace_nxt       = grace_r;
    monitoring_nxt  = monitoring_r;
    last_seen_nxt   = last_seen_r;
    last_change_nxt = last_change_r;
    frozen_nxt      = frozen_r;
    fault_nxt       = fault_r;
    normal_nxt      = normal_r;
    ent_frz         = 1'b0;
    ent_to          = 1'b0;
    ent_nrm         = 1'b0;

    // grace re-captures the value, so no change is seen on those ticks
    seen_ref = grace_r ? item.partner_value : last_seen_r;
    changed  = item.partner_value != seen_ref;
    frz0     = frozen_r;
    flt0     = fault_r;
    nrm0     = normal_r;
    if (grace_r && grace_end) begin
      frz0 = 1'b0;
      flt0 = 1'b0;
      nrm0 = 1'b0;
    end

    if (grace_r || changed) last_change_nxt = item.now_ms;
    else                    last_change_nxt = last_change_r;

    // a stamp that lies ahead of now never counts as stale
    change_age   = item.now_ms - last_change_nxt;
    update_age   = item.now_ms - item.partner_update_ms;
    stale_change = (last_change_nxt <= item.now_ms) && (change_age > timeout_ext);
    stale_update = (item.partner_update_ms <= item.now_ms) && (update_age > timeout_ext);

    if (cfg.read_present) begin
      sum           = item.partner_value + 64'd1;
      last_seen_nxt = item.partner_value;
      if (grace_r && grace_end) grace_nxt = 1'b0;
      if (changed) monitoring_nxt = 1'b1;
      frozen_nxt = frz0;
      fault_nxt  = flt0;
      normal_nxt = nrm0;
      if (monitoring_r || changed) begin
        if (stale_change) begin
          frozen_nxt = 1'b1;
          ent_frz    = !frz0;
        end
        if (stale_update) begin
          fault_nxt = 1'b1;
          ent_to    = !flt0;
        end
        if (!stale_change && !stale_update) begin
          if (!nrm0) begin
            frozen_nxt = 1'b0;
            fault_nxt  = 1'b0;
            normal_nxt = 1'b1;
            ent_nrm    = 1'b1;
          end
        end else begin
          normal_nxt = 1'b0;
        end
      end
    end else begin
      sum             = own_count_r + 64'd1;
      last_change_nxt = last_change_r;
    end

    if ((cfg.wrap_limit != '0) && (sum > cfg.wrap_limit)) own_count_nxt = '0;
    else                                                  own_count_nxt = sum;

    result_nxt.heartbeat_out   = own_count_nxt;
    result_nxt.write_request   = cfg.send_enable && cfg.read_present && cfg.write_present;
    result_nxt.is_frozen       = frozen_nxt;
    result_nxt.is_timed_out    = fault_nxt;
    result_nxt.is_normal       = normal_nxt;
    result_nxt.entered_frozen  = ent_frz;
    result_nxt.entered_timeout = ent_to;
    result_nxt.entered_normal  = ent_nrm;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grace_r       <= 1'b1;
      monitoring_r  <= 1'b0;
      last_seen_r   <= '0;
      last_change_r <= '0;
      frozen_r      <= 1'b0;
      fault_r       <= 1'b0;
      normal_r      <= 1'b0;
      own_count_r   <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (advance) out_valid_r <= item_valid;
      if (advance && item_valid) begin
        grace_r       <= grace_nxt;
        monitoring_r  <= monitoring_nxt;
        last_seen_r   <= last_seen_nxt;
        last_change_r <= last_change_nxt;
        frozen_r      <= frozen_nxt;
        fault_r       <= fault_nxt;
        normal_r      <= normal_nxt;
        own_count_r   <= own_count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && item_valid) result_r <= result_nxt;
  end

  assign out_valid = out_valid_r;
  assign result    = result_r;

endmodule
`default_nettype wire
